@@ rtl/sstc_pkg.sv @@
// Shared types and constants for the stick scale, trim and calibrate block.
// Used by sstc_scale, sstc_cal and stick_scale_trim_calibrate; no dependencies.
package sstc_pkg;

	// Converter and channel value ranges
	localparam int unsigned ADC_BITS = 12;
	localparam int unsigned ADC_MAX  = (1 << ADC_BITS) - 1;
	localparam int unsigned VAL_W    = 11;
	localparam int unsigned BIAS_W   = 12;
	localparam int unsigned STEP_W   = 7;
	localparam int unsigned NUM_CH   = 4;

	localparam logic [VAL_W-1:0] VALUE_MIN     = 11'd1000;
	localparam logic [VAL_W-1:0] VALUE_MAX     = 11'd2000;
	localparam logic [VAL_W-1:0] STICK_CENTER  = 11'd1500;
	localparam logic [9:0]       SCALE_GAIN    = 10'd1000;

	// Reset values of the configuration registers
	localparam logic [VAL_W-1:0]  IDLE_LIMIT_RST = 11'd1015;
	localparam logic [STEP_W-1:0] TRIM_STEP_RST  = 7'd10;

	// Default number of samples averaged by a calibration
	localparam int unsigned CAL_SAMPLES_DEF = 60;

	// Channel positions
	localparam logic [1:0] CH_ROLL     = 2'd0;
	localparam logic [1:0] CH_PITCH    = 2'd1;
	localparam logic [1:0] CH_YAW      = 2'd2;
	localparam logic [1:0] CH_THROTTLE = 2'd3;

	typedef logic [ADC_BITS-1:0]      adc_t;
	typedef logic [VAL_W-1:0]         value_t;
	typedef logic signed [BIAS_W-1:0] bias_t;
	typedef logic [STEP_W-1:0]        step_t;

	typedef enum logic [2:0] {
		ACT_SAMPLE     = 3'd0,
		ACT_CAL_START  = 3'd1,
		ACT_ROLL_UP    = 3'd2,
		ACT_ROLL_DOWN  = 3'd3,
		ACT_PITCH_UP   = 3'd4,
		ACT_PITCH_DOWN = 3'd5
	} action_t;

	typedef enum logic {
		REG_IDLE_LIMIT = 1'b0,
		REG_TRIM_STEP  = 1'b1
	} reg_index_t;

	// Status that goes with one result
	typedef struct packed {
		logic calibrating;
		logic done;
		logic at_ref;
	} flags_t;

endpackage

@@ rtl/sstc_scale.sv @@
// One stick channel: scale a raw converter sample to 1000..2000, remove bias, clamp.
// Depends on sstc_pkg.
module sstc_scale (
	input  sstc_pkg::adc_t   adc,
	input  sstc_pkg::bias_t  bias,
	output sstc_pkg::value_t value
);
	import sstc_pkg::*;

	localparam int unsigned PROD_W = ADC_BITS + 10;

	logic [PROD_W-1:0]   prod;
	logic [9:0]          quo_est;
	logic [ADC_BITS:0]   rem;
	logic [9:0]          quo;
	logic [VAL_W-1:0]    base;
	logic signed [13:0]  diff;

	// Divide adc*1000 by 2^N-1: estimate by shift, one correction step
	always_comb begin
		prod    = PROD_W'(adc) * PROD_W'(SCALE_GAIN);
		quo_est = prod[PROD_W-1:ADC_BITS];
		rem     = {1'b0, prod[ADC_BITS-1:0]} + (ADC_BITS+1)'(quo_est);
		quo     = quo_est + 10'(rem >= (ADC_BITS+1)'(ADC_MAX));
		base    = VALUE_MIN + VAL_W'(quo);
		diff    = $signed({3'b000, base}) - $signed({{2{bias[BIAS_W-1]}}, bias});
	end

	// Clamp to the valid channel range
	always_comb begin
		if (diff < $signed({3'b000, VALUE_MIN})) begin
			value = VALUE_MIN;
		end else if (diff > $signed({3'b000, VALUE_MAX})) begin
			value = VALUE_MAX;
		end else begin
			value = diff[VAL_W-1:0];
		end
	end

endmodule

@@ rtl/sstc_cal.sv @@
// Bias, trim and calibration state: applies one action per go strobe, and
// turns finished sample sums into new biases in the following cycle. Depends on sstc_pkg.
module sstc_cal #(
	parameter int unsigned CAL_SAMPLES = sstc_pkg::CAL_SAMPLES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               go,
	input  sstc_pkg::action_t                  action,
	input  sstc_pkg::value_t [3:0]             scaled,
	input  sstc_pkg::value_t                   idle_limit,
	input  sstc_pkg::step_t                    trim_step,
	output sstc_pkg::bias_t  [3:0]             bias,
	output sstc_pkg::value_t [3:0]             result_vals,
	output sstc_pkg::flags_t                   flags,
	output logic                               busy
);
	import sstc_pkg::*;

	localparam int unsigned SUM_W    = $clog2(CAL_SAMPLES * 2000 + 1);
	localparam int unsigned CNT_W    = $clog2(CAL_SAMPLES + 1);
	localparam int unsigned RECIP_SH = SUM_W + CNT_W;
	localparam longint unsigned RECIP_L =
		((64'd1 << RECIP_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
	localparam logic [RECIP_SH:0] RECIP = (RECIP_SH+1)'(RECIP_L);
	localparam int unsigned AVG_PROD_W = SUM_W + RECIP_SH + 1;

	bias_t  [3:0]            bias_q, bias_d;
	bias_t  [3:0]            ref_q, ref_d;
	logic   [3:0][SUM_W-1:0] sum_q, sum_d;
	logic   [CNT_W-1:0]      cnt_q, cnt_d, cnt_inc;
	logic                    mode_q, mode_d;
	value_t [3:0]            last_q, last_d;
	logic                    fin_q, fin_d;

	logic   [1:0]            trim_ch;
	logic                    trim_down;
	logic signed [BIAS_W:0]  trim_sum;
	bias_t                   trim_bias;

	logic   [3:0][AVG_PROD_W-1:0] avg_prod;
	value_t [3:0]                 avg;
	bias_t  [3:0]                 fin_bias;

	// Trimmed bias, saturated to the 12-bit range
	always_comb begin
		trim_ch   = (action == ACT_ROLL_UP || action == ACT_ROLL_DOWN) ? CH_ROLL : CH_PITCH;
		trim_down = (action == ACT_ROLL_DOWN || action == ACT_PITCH_DOWN);
		if (trim_down) begin
			trim_sum = $signed({bias_q[trim_ch][BIAS_W-1], bias_q[trim_ch]})
				- $signed({{(BIAS_W+1-STEP_W){1'b0}}, trim_step});
		end else begin
			trim_sum = $signed({bias_q[trim_ch][BIAS_W-1], bias_q[trim_ch]})
				+ $signed({{(BIAS_W+1-STEP_W){1'b0}}, trim_step});
		end
		if (trim_sum[BIAS_W] != trim_sum[BIAS_W-1]) begin
			trim_bias = trim_sum[BIAS_W] ? {1'b1, {(BIAS_W-1){1'b0}}}
				: {1'b0, {(BIAS_W-1){1'b1}}};
		end else begin
			trim_bias = trim_sum[BIAS_W-1:0];
		end
	end

	// Average by reciprocal multiply, then offset to a bias
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			avg_prod[i] = AVG_PROD_W'(sum_q[i]) * AVG_PROD_W'(RECIP);
			avg[i]      = avg_prod[i][RECIP_SH +: VAL_W];
			if (i == int'(CH_THROTTLE)) begin
				fin_bias[i] = bias_t'({1'b0, avg[i]} - {1'b0, VALUE_MIN});
			end else begin
				fin_bias[i] = bias_t'({1'b0, avg[i]} - {1'b0, STICK_CENTER});
			end
		end
	end

	// Next state for one action, or for the bias update after a finished calibration
	always_comb begin
		bias_d  = bias_q;
		ref_d   = ref_q;
		sum_d   = sum_q;
		cnt_d   = cnt_q;
		mode_d  = mode_q;
		last_d  = last_q;
		fin_d   = 1'b0;
		flags   = '0;
		cnt_inc = cnt_q + 1'b1;
		if (fin_q) begin
			bias_d = fin_bias;
			ref_d  = fin_bias;
		end else if (go) begin
			case (action)
				ACT_SAMPLE: begin
					last_d = scaled;
					if (mode_q && scaled[CH_THROTTLE] < idle_limit) begin
						cnt_d = cnt_inc;
						for (int i = 0; i < NUM_CH; i++) begin
							if (cnt_q == '0) begin
								sum_d[i]  = SUM_W'(scaled[i]);
								bias_d[i] = '0;
							end else begin
								sum_d[i] = sum_q[i] + SUM_W'(scaled[i]);
							end
						end
						if (cnt_inc == CNT_W'(CAL_SAMPLES)) begin
							cnt_d      = '0;
							mode_d     = 1'b0;
							fin_d      = 1'b1;
							flags.done = 1'b1;
						end
					end
				end
				ACT_CAL_START: begin
					mode_d = 1'b1;
				end
				ACT_ROLL_UP, ACT_ROLL_DOWN, ACT_PITCH_UP, ACT_PITCH_DOWN: begin
					bias_d[trim_ch] = trim_bias;
					flags.at_ref    = (trim_bias == ref_q[trim_ch]);
				end
				default: begin
				end
			endcase
		end
		flags.calibrating = mode_d;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
			ref_q  <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
			mode_q <= 1'b0;
			last_q <= {NUM_CH{VALUE_MIN}};
			fin_q  <= 1'b0;
		end else begin
			bias_q <= bias_d;
			ref_q  <= ref_d;
			sum_q  <= sum_d;
			cnt_q  <= cnt_d;
			mode_q <= mode_d;
			last_q <= last_d;
			fin_q  <= fin_d;
		end
	end

	assign bias        = bias_q;
	assign result_vals = last_d;
	assign busy        = fin_q;

endmodule

@@ rtl/stick_scale_trim_calibrate.sv @@
// Stick scale, trim and calibrate. An accepted item passes the input register, one
// combinational pass and the output register, waiting while the result slot is full.
// Throughput: one item per cycle unless m_tready stalls; the cycle after a sample that
// completes calibration takes no item while the four sums are divided into new biases.
// Reset (arst_n low, asynchronous): biases, references and sums zero, values 1000,
// calibration off, idle limit 1015, trim step 10. Depends on sstc_pkg, sstc_scale, sstc_cal.
module stick_scale_trim_calibrate #(
	parameter int unsigned CAL_SAMPLES = sstc_pkg::CAL_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// adc_roll[11:0], adc_pitch[23:12], adc_yaw[35:24], adc_throttle[47:36]
	input  logic [47:0] s_tdata,
	// action[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// roll_value[10:0], pitch_value[21:11], yaw_value[32:22], throttle_value[43:33],
	// calibrating[44], calibration_done[45], trim_at_reference[46], zero[47]
	output logic [47:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);
	import sstc_pkg::*;

	logic            valid_s1;
	action_t         action_s1;
	adc_t   [3:0]    adc_s1;
	logic            go;
	logic            busy;
	logic            out_free;
	logic            m_tvalid_q;
	logic   [47:0]   m_tdata_q;
	value_t          idle_limit_q;
	step_t           trim_step_q;
	bias_t  [3:0]    bias;
	value_t [3:0]    scaled;
	value_t [3:0]    result_vals;
	flags_t          flags;

	// Advance an item when the result slot is free and no bias update is pending
	assign out_free = !m_tvalid_q || m_tready;
	assign go       = valid_s1 && out_free && !busy;
	assign s_tready = !valid_s1 || go;
	assign cfg_ready = 1'b1;

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= action_t'(s_tuser);
			for (int i = 0; i < NUM_CH; i++) begin
				adc_s1[i] <= s_tdata[i*ADC_BITS +: ADC_BITS];
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= IDLE_LIMIT_RST;
			trim_step_q  <= TRIM_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IDLE_LIMIT: idle_limit_q <= cfg_data;
				REG_TRIM_STEP:  trim_step_q  <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Four channel scalers
	for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
		sstc_scale u_scale (
			.adc   (adc_s1[g]),
			.bias  (bias[g]),
			.value (scaled[g])
		);
	end

	sstc_cal #(
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_cal (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.action      (action_s1),
		.scaled      (scaled),
		.idle_limit  (idle_limit_q),
		.trim_step   (trim_step_q),
		.bias        (bias),
		.result_vals (result_vals),
		.flags       (flags),
		.busy        (busy)
	);

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (go) begin
			m_tdata_q <= {1'b0, flags.at_ref, flags.done, flags.calibrating,
				result_vals[CH_THROTTLE], result_vals[CH_YAW],
				result_vals[CH_PITCH], result_vals[CH_ROLL]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
